>>> rtl/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int unsigned NORMAL_W  = 18;
  localparam int unsigned RESTIT_W  = 17;
  localparam int unsigned RADIUS_W  = 31;
  localparam int unsigned DEPTH_W   = 33;  // penetration depth p, Q16.16
  localparam int unsigned VDOT_W    = 36;  // rounded v . n, Q16.16
  localparam int unsigned SAT_IN_W  = 42;

  localparam logic [RESTIT_W:0]        Q16_ONE     = 18'd65536;
  localparam logic signed [NORMAL_W-1:0] NORMAL_Y_RST = 18'sd65536;

  typedef logic signed [31:0]          q16_t;
  typedef logic signed [NORMAL_W-1:0]  normal_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_RESTITUTION  = 3'd4
  } ppc_reg_t;

  typedef struct packed {
    normal_t              normal_x;
    normal_t              normal_y;
    normal_t              normal_z;
    q16_t                 plane_offset;
    logic [RESTIT_W-1:0]  restitution;
  } ppc_cfg_t;

  // item handed from the distance pipeline to the response pipeline
  typedef struct packed {
    logic                       hit;
    logic                       fixed;
    logic signed [DEPTH_W-1:0]  p;
    logic signed [VDOT_W-1:0]   w;
    q16_t [2:0]                 x;
    q16_t [2:0]                 v;
  } ppc_mid_t;

  function automatic q16_t sat32(input logic signed [SAT_IN_W-1:0] a);
    q16_t res;
    if (a > 42'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (a < -42'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = a[31:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/ppc_in_if.sv
`timescale 1ns / 1ps

interface ppc_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  pos_z;
  logic signed [31:0]  vel_x;
  logic signed [31:0]  vel_y;
  logic signed [31:0]  vel_z;
  logic [30:0]         radius;
  logic                is_fixed;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, is_fixed,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, is_fixed,
    output ready
  );
endinterface

>>> rtl/ppc_out_if.sv
`timescale 1ns / 1ps

interface ppc_out_if;
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [31:0]  new_pos_x;
  logic signed [31:0]  new_pos_y;
  logic signed [31:0]  new_pos_z;
  logic signed [31:0]  new_vel_x;
  logic signed [31:0]  new_vel_y;
  logic signed [31:0]  new_vel_z;

  modport source (
    output valid, hit, new_pos_x, new_pos_y, new_pos_z,
           new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );

  modport sink (
    input  valid, hit, new_pos_x, new_pos_y, new_pos_z,
           new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

>>> rtl/ppc_cfg_regs.sv
`timescale 1ns / 1ps

module ppc_cfg_regs
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output ppc_cfg_t    cfg
);

  ppc_cfg_t cfg_r;
  ppc_reg_t sel;
  logic     wr_en;

  assign sel        = ppc_reg_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_x     <= '0;
      cfg_r.normal_y     <= NORMAL_Y_RST;
      cfg_r.normal_z     <= '0;
      cfg_r.plane_offset <= '0;
      cfg_r.restitution  <= Q16_ONE[RESTIT_W-1:0];
    end else if (wr_en) begin
      case (sel)
        REG_NORMAL_X:     cfg_r.normal_x     <= cfg_pwdata[NORMAL_W-1:0];
        REG_NORMAL_Y:     cfg_r.normal_y     <= cfg_pwdata[NORMAL_W-1:0];
        REG_NORMAL_Z:     cfg_r.normal_z     <= cfg_pwdata[NORMAL_W-1:0];
        REG_PLANE_OFFSET: cfg_r.plane_offset <= cfg_pwdata;
        REG_RESTITUTION:  cfg_r.restitution  <= cfg_pwdata[RESTIT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_NORMAL_X:     cfg_prdata = 32'(cfg_r.normal_x);
      REG_NORMAL_Y:     cfg_prdata = 32'(cfg_r.normal_y);
      REG_NORMAL_Z:     cfg_prdata = 32'(cfg_r.normal_z);
      REG_PLANE_OFFSET: cfg_prdata = cfg_r.plane_offset;
      REG_RESTITUTION:  cfg_prdata = 32'(cfg_r.restitution);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule

>>> rtl/ppc_dot.sv
`timescale 1ns / 1ps

module ppc_dot
  import ppc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ppc_cfg_t  cfg,
  ppc_in_if.sink    in_ch,
  output logic      mid_valid,
  input  logic      mid_ready,
  output ppc_mid_t  mid_item
);

  normal_t n [3];
  q16_t    x_in [3];
  q16_t    v_in [3];

  assign n[0] = cfg.normal_x;
  assign n[1] = cfg.normal_y;
  assign n[2] = cfg.normal_z;
  assign x_in[0] = in_ch.pos_x;
  assign x_in[1] = in_ch.pos_y;
  assign x_in[2] = in_ch.pos_z;
  assign v_in[0] = in_ch.vel_x;
  assign v_in[1] = in_ch.vel_y;
  assign v_in[2] = in_ch.vel_z;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready    = !s4_valid_r || mid_ready;
  assign s3_ready    = !s3_valid_r || s4_ready;
  assign s2_ready    = !s2_valid_r || s3_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_ch.valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
    end
  end

  // stage 1: component products
  logic signed [49:0]   s1_xn_r [3];
  logic signed [49:0]   s1_vn_r [3];
  q16_t                 s1_x_r [3];
  q16_t                 s1_v_r [3];
  logic [RADIUS_W-1:0]  s1_r_r;
  logic                 s1_fixed_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      for (int i = 0; i < 3; i++) begin
        s1_xn_r[i] <= x_in[i] * n[i];
        s1_vn_r[i] <= v_in[i] * n[i];
        s1_x_r[i]  <= x_in[i];
        s1_v_r[i]  <= v_in[i];
      end
      s1_r_r     <= in_ch.radius;
      s1_fixed_r <= in_ch.is_fixed;
    end
  end

  // stage 2: dot sums and signed distance
  logic signed [51:0]   dxn;
  logic signed [52:0]   s_nxt;
  logic signed [51:0]   dvn_nxt;
  logic signed [52:0]   s2_s_r;
  logic signed [51:0]   s2_dvn_r;
  q16_t                 s2_x_r [3];
  q16_t                 s2_v_r [3];
  logic [RADIUS_W-1:0]  s2_r_r;
  logic                 s2_fixed_r;

  always_comb begin
    dxn     = 52'(s1_xn_r[0]) + 52'(s1_xn_r[1]) + 52'(s1_xn_r[2]);
    dvn_nxt = 52'(s1_vn_r[0]) + 52'(s1_vn_r[1]) + 52'(s1_vn_r[2]);
    s_nxt   = 53'(dxn) - (53'(cfg.plane_offset) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_s_r     <= s_nxt;
      s2_dvn_r   <= dvn_nxt;
      s2_x_r     <= s1_x_r;
      s2_v_r     <= s1_v_r;
      s2_r_r     <= s1_r_r;
      s2_fixed_r <= s1_fixed_r;
    end
  end

  // stage 3: |s| and rounded v . n
  logic [52:0]               abs_nxt;
  logic signed [51:0]        dvn_rnd;
  logic [52:0]               s3_abs_r;
  logic signed [VDOT_W-1:0]  s3_w_r;
  q16_t                      s3_x_r [3];
  q16_t                      s3_v_r [3];
  logic [RADIUS_W-1:0]       s3_r_r;
  logic                      s3_fixed_r;

  always_comb begin
    abs_nxt = s2_s_r[52] ? 53'(-s2_s_r) : 53'(s2_s_r);
    dvn_rnd = s2_dvn_r + 52'sd32768;
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_abs_r   <= abs_nxt;
      s3_w_r     <= $signed(dvn_rnd[51:16]);
      s3_x_r     <= s2_x_r;
      s3_v_r     <= s2_v_r;
      s3_r_r     <= s2_r_r;
      s3_fixed_r <= s2_fixed_r;
    end
  end

  // stage 4: hit test and rounded penetration depth
  logic [53:0]         abs_rnd;
  logic signed [38:0]  p_full;
  logic                hit_nxt;
  ppc_mid_t            s4_item_r;

  always_comb begin
    hit_nxt = s3_abs_r <= {6'd0, s3_r_r, 16'd0};
    abs_rnd = 54'(s3_abs_r) + 54'd32768;
    // r is Q16.16, so subtract it after the shift brings |s| to Q16.16
    p_full  = $signed({1'b0, abs_rnd[53:16]}) - $signed({8'd0, s3_r_r});
  end

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_item_r.hit   <= hit_nxt;
      s4_item_r.fixed <= s3_fixed_r;
      s4_item_r.p     <= p_full[DEPTH_W-1:0];
      s4_item_r.w     <= s3_w_r;
      for (int i = 0; i < 3; i++) begin
        s4_item_r.x[i] <= s3_x_r[i];
        s4_item_r.v[i] <= s3_v_r[i];
      end
    end
  end

  assign mid_valid = s4_valid_r;
  assign mid_item  = s4_item_r;

endmodule

>>> rtl/ppc_resolve.sv
`timescale 1ns / 1ps

module ppc_resolve
  import ppc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ppc_cfg_t  cfg,
  input  logic      mid_valid,
  output logic      mid_ready,
  input  ppc_mid_t  mid_item,
  ppc_out_if.source out_ch
);

  normal_t n [3];

  assign n[0] = cfg.normal_x;
  assign n[1] = cfg.normal_y;
  assign n[2] = cfg.normal_z;

  logic s5_valid_r, s6_valid_r, s7_valid_r, s8_valid_r;
  logic s5_ready, s6_ready, s7_ready, s8_ready;

  assign s8_ready  = !s8_valid_r || out_ch.ready;
  assign s7_ready  = !s7_valid_r || s8_ready;
  assign s6_ready  = !s6_valid_r || s7_ready;
  assign s5_ready  = !s5_valid_r || s6_ready;
  assign mid_ready = s5_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else begin
      if (s5_ready) s5_valid_r <= mid_valid;
      if (s6_ready) s6_valid_r <= s5_valid_r;
      if (s7_ready) s7_valid_r <= s6_valid_r;
      if (s8_ready) s8_valid_r <= s7_valid_r;
    end
  end

  // stage 5: (1 + e) * w and p * n
  logic signed [RESTIT_W+1:0]  k;
  logic signed [54:0]          s5_kw_r;
  logic signed [50:0]          s5_pn_r [3];
  q16_t                        s5_x_r [3];
  q16_t                        s5_v_r [3];
  logic                        s5_act_r;
  logic                        s5_hit_r;

  assign k = $signed({1'b0, Q16_ONE + (RESTIT_W+1)'(cfg.restitution)});

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_kw_r  <= k * mid_item.w;
      for (int i = 0; i < 3; i++) begin
        s5_pn_r[i] <= mid_item.p * n[i];
        s5_x_r[i]  <= mid_item.x[i];
        s5_v_r[i]  <= mid_item.v[i];
      end
      s5_act_r <= mid_item.hit && !mid_item.fixed;
      s5_hit_r <= mid_item.hit;
    end
  end

  // stage 6: round q, resolve position
  logic signed [54:0]  kw_rnd;
  logic signed [50:0]  pn_rnd [3];
  logic signed [35:0]  pos_diff [3];
  q16_t                pos_nxt [3];
  logic signed [38:0]  s6_q_r;
  q16_t                s6_pos_r [3];
  q16_t                s6_v_r [3];
  logic                s6_act_r;
  logic                s6_hit_r;

  always_comb begin
    kw_rnd = s5_kw_r + 55'sd32768;
    for (int i = 0; i < 3; i++) begin
      pn_rnd[i]   = s5_pn_r[i] + 51'sd32768;
      pos_diff[i] = 36'(s5_x_r[i]) - 36'($signed(pn_rnd[i][50:16]));
      pos_nxt[i]  = s5_act_r ? sat32(SAT_IN_W'(pos_diff[i])) : s5_x_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s6_ready) begin
      s6_q_r   <= $signed(kw_rnd[54:16]);
      s6_pos_r <= pos_nxt;
      s6_v_r   <= s5_v_r;
      s6_act_r <= s5_act_r;
      s6_hit_r <= s5_hit_r;
    end
  end

  // stage 7: q * n
  logic signed [56:0]  s7_qn_r [3];
  q16_t                s7_pos_r [3];
  q16_t                s7_v_r [3];
  logic                s7_act_r;
  logic                s7_hit_r;

  always_ff @(posedge clk) begin
    if (s7_ready) begin
      for (int i = 0; i < 3; i++) begin
        s7_qn_r[i] <= s6_q_r * n[i];
      end
      s7_pos_r <= s6_pos_r;
      s7_v_r   <= s6_v_r;
      s7_act_r <= s6_act_r;
      s7_hit_r <= s6_hit_r;
    end
  end

  // stage 8: resolve velocity into the output register
  logic signed [56:0]          qn_rnd [3];
  logic signed [SAT_IN_W-1:0]  vel_diff [3];
  q16_t                        vel_nxt [3];
  q16_t                        s8_pos_r [3];
  q16_t                        s8_vel_r [3];
  logic                        s8_hit_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qn_rnd[i]   = s7_qn_r[i] + 57'sd32768;
      vel_diff[i] = SAT_IN_W'(s7_v_r[i]) - SAT_IN_W'($signed(qn_rnd[i][56:16]));
      vel_nxt[i]  = s7_act_r ? sat32(vel_diff[i]) : s7_v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s8_ready) begin
      s8_pos_r <= s7_pos_r;
      s8_vel_r <= vel_nxt;
      s8_hit_r <= s7_hit_r;
    end
  end

  assign out_ch.valid     = s8_valid_r;
  assign out_ch.hit       = s8_hit_r;
  assign out_ch.new_pos_x = s8_pos_r[0];
  assign out_ch.new_pos_y = s8_pos_r[1];
  assign out_ch.new_pos_z = s8_pos_r[2];
  assign out_ch.new_vel_x = s8_vel_r[0];
  assign out_ch.new_vel_y = s8_vel_r[1];
  assign out_ch.new_vel_z = s8_vel_r[2];

endmodule

>>> rtl/particle_plane_collision_top.sv
// Sphere-plane collision response for a stream of particles, all values
// Q16.16 fixed point. Each input transfer carries one particle (position,
// velocity, radius, fixed flag) and yields exactly one output transfer with
// the hit flag and the resolved position and velocity, saturated to 32 bits.
// The plane normal, offset and restitution come from the APB registers at
// byte addresses 0x00 to 0x10 and must only be written while no particle is
// in flight. The block accepts one particle every cycle while the output is
// not stalled. Four stages form the two dot products, the signed distance
// and the hit test, four more form the position and velocity corrections
// with a register after each multiplier. A stalled output holds its result
// while the pipeline keeps filling its empty stages behind it.
`timescale 1ns / 1ps

module particle_plane_collision_top
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ppc_in_if.sink      in_ch,
  ppc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ppc_cfg_t cfg;
  logic     mid_valid;
  logic     mid_ready;
  ppc_mid_t mid_item;

  // register file; the user must let writes land only while the pipeline is drained, as the block does no check
  ppc_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // distance pipeline: products, sums, |s|, hit test and depth
  ppc_dot u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .mid_valid(mid_valid),
    .mid_ready(mid_ready),
    .mid_item (mid_item)
  );

  // response pipeline: for a hit on a free particle, move it out and reflect the velocity
  ppc_resolve u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .mid_valid(mid_valid),
    .mid_ready(mid_ready),
    .mid_item (mid_item),
    .out_ch   (out_ch)
  );

  // a hit always means the sphere reaches the plane: depth is never positive
  a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_valid && mid_item.hit) |-> (mid_item.p <= 0))
    else $error("hit with positive penetration depth");

  // an open output lets every stage advance, so the input must be open too
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is open");

  // a stalled item between the two pipelines must hold
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_item)))
    else $error("stalled mid-pipeline item lost or changed");

endmodule
